[hw/rtl/dkpw_pkg.sv]
// shared constants, payload types and cell control types for the day keyed price window
`timescale 1ns / 1ps
`default_nettype none
package dkpw_pkg;

  // window geometry
  localparam int WINDOW_DEPTH    = 32;
  localparam int SECONDS_PER_DAY = 86400;
  // one spare cell holds the newcomer until the oldest day is evicted
  localparam int NCELL           = WINDOW_DEPTH + 1;
  localparam int COUNT_W         = $clog2(NCELL + 1);

  // field widths
  localparam int DAY_W   = 24;
  localparam int PRICE_W = 48;
  localparam int EPOCH_W = 40;
  localparam int CFG_W   = 6;
  localparam int FILL_W  = 6;
  localparam int LIM_W   = (CFG_W > COUNT_W) ? CFG_W : COUNT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // day from seconds by reciprocal multiply: day = (secs * RECIP) >> RECIP_SHIFT
  // the rounded-up reciprocal is exact for every time that fits in EPOCH_W bits
  localparam int RECIP_SHIFT = EPOCH_W + $clog2(SECONDS_PER_DAY);
  localparam int RECIP_W     = EPOCH_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(SECONDS_PER_DAY) - 64'd1) / 64'(SECONDS_PER_DAY);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  // the time is multiplied in two halves, one per cycle
  localparam int HALF_W  = EPOCH_W / 2;
  localparam int MUL_A_W = EPOCH_W - HALF_W;
  localparam int PROD_W  = MUL_A_W + RECIP_W;
  localparam int ACC_W   = EPOCH_W + RECIP_W;

  // command and status codes
  localparam logic CMD_ADD       = 1'b0;
  localparam logic CMD_DUMP      = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic                      command;
    logic signed [PRICE_W-1:0] price;
    logic [EPOCH_W-1:0]        tick_secs;
  } in_t;

  typedef struct packed {
    logic                      status;
    logic                      entry_valid;
    logic [DAY_W-1:0]          entry_day;
    logic signed [PRICE_W-1:0] entry_price;
    logic                      last_result;
    logic [FILL_W-1:0]         fill_count;
    logic                      window_ready;
  } out_t;

  typedef struct packed {
    logic [DAY_W-1:0]          day;
    logic signed [PRICE_W-1:0] price;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    entry_t     new_entry;
  } cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/dkpw_divider.sv]
// day number from epoch seconds by reciprocal multiply, one half-width product per cycle
`timescale 1ns / 1ps
`default_nettype none
module dkpw_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dkpw_pkg::EPOCH_W-1:0]  dividend,
  output logic                               done,
  output logic [dkpw_pkg::DAY_W-1:0]         day
);

  logic                              busy_r;
  logic                              done_r;
  logic                              step_r;
  logic [dkpw_pkg::EPOCH_W-1:0]      num_r;
  logic [dkpw_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [dkpw_pkg::MUL_A_W-1:0]      mul_a;
  logic [dkpw_pkg::PROD_W-1:0]       prod;

  // low half of the time first, then the high half added in at its weight
  always_comb begin
    if (!step_r) begin
      mul_a = dkpw_pkg::MUL_A_W'(num_r[dkpw_pkg::HALF_W-1:0]);
    end else begin
      mul_a = num_r[dkpw_pkg::EPOCH_W-1:dkpw_pkg::HALF_W];
    end
    prod = dkpw_pkg::PROD_W'(mul_a) * dkpw_pkg::PROD_W'(dkpw_pkg::RECIP);
    if (!step_r) begin
      acc_nxt = dkpw_pkg::ACC_W'(prod);
    end else begin
      acc_nxt = acc_r + (dkpw_pkg::ACC_W'(prod) << dkpw_pkg::HALF_W);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= 1'b1;
        if (step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  // low day bits of the scaled product
  assign day  = acc_r[dkpw_pkg::RECIP_SHIFT +: dkpw_pkg::DAY_W];

endmodule
`default_nettype wire

[hw/rtl/dkpw_cell.sv]
// one window slot: holds a day and price, compares against the newcomer, trades with neighbors
`timescale 1ns / 1ps
`default_nettype none
module dkpw_cell (
  input  wire logic                clk,
  input  wire dkpw_pkg::cell_ctl_t ctl,
  input  wire dkpw_pkg::entry_t    left_entry,
  input  wire logic                left_lt,
  input  wire dkpw_pkg::entry_t    right_entry,
  input  wire dkpw_pkg::entry_t    wrap_entry,
  input  wire logic                live,
  input  wire logic                tail,
  output dkpw_pkg::entry_t         entry,
  output logic                     lt,
  output logic                     eq
);

  dkpw_pkg::entry_t entry_r, entry_nxt;

  // compare only slots that hold a stored day
  assign lt = live && (entry_r.day < ctl.new_entry.day);
  assign eq = live && (entry_r.day == ctl.new_entry.day);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      dkpw_pkg::CELL_HOLD: begin
        entry_nxt = entry_r;
      end
      dkpw_pkg::CELL_INSERT: begin
        if (ctl.hit) begin
          // same day stored: overwrite its price
          if (eq) entry_nxt.price = ctl.new_entry.price;
        end else if (!lt) begin
          // first slot past the older days takes the newcomer, the rest move up
          entry_nxt = left_lt ? ctl.new_entry : left_entry;
        end
      end
      dkpw_pkg::CELL_SHIFT: begin
        entry_nxt = right_entry;
      end
      dkpw_pkg::CELL_ROTATE: begin
        entry_nxt = tail ? wrap_entry : right_entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

[hw/rtl/day_keyed_price_window_core.sv]
// top level: request handling, day divider and the sorted chain of window cells
//
//  channel | ports                        | payload
//  --------+------------------------------+-------------------------------
//  input   | in_valid / in_ready          | in_data  (dkpw_pkg::in_t)
//  result  | out_valid / out_ready        | out_data (dkpw_pkg::out_t)
//  config  | cfg_valid / cfg_ready        | cfg_data (window limit, 6 bits)
//
// one request at a time; an add goes through accept, the two multiply halves
// for the day, the hand-over of the day, the insert, the eviction check and
// the result load; each evicted day repeats the eviction step. a rejected
// add or empty dump goes from accept straight to the result. a dump gives one
// entry per cycle while results are taken, by rotating the cell chain. the
// result register frees the input side while a result waits; a stalled result
// holds the chain. reset is synchronous and leaves the window empty, limit 32.
`timescale 1ns / 1ps
`default_nettype none
module day_keyed_price_window_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dkpw_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dkpw_pkg::out_t                  out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [dkpw_pkg::CFG_W-1:0] cfg_data
);

  localparam int NCELL   = dkpw_pkg::NCELL;
  localparam int COUNT_W = dkpw_pkg::COUNT_W;
  localparam int LIM_W   = dkpw_pkg::LIM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;
  localparam logic [2:0] ST_DUMP  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [COUNT_W-1:0]              count_r, count_nxt;
  logic [COUNT_W-1:0]              dump_idx_r, dump_idx_nxt;
  logic [dkpw_pkg::CFG_W-1:0]      lim_r;
  logic                            resp_status_r, resp_status_nxt;
  logic signed [dkpw_pkg::PRICE_W-1:0] price_r;
  dkpw_pkg::out_t                  out_r, out_nxt;
  logic                            out_valid_r;

  logic                            accept;
  logic                            nonpos;
  logic                            div_start;
  logic                            div_done;
  logic [dkpw_pkg::DAY_W-1:0]      div_day;
  logic                            out_free;
  logic                            out_load;
  logic                            dump_last;
  logic                            over_limit;
  logic [LIM_W-1:0]                lim_ext;
  logic [LIM_W-1:0]                eff_lim;
  logic                            any_hit;

  dkpw_pkg::cell_ctl_t             ctl;
  dkpw_pkg::entry_t                cell_e  [NCELL];
  dkpw_pkg::entry_t                left_e  [NCELL];
  dkpw_pkg::entry_t                right_e [NCELL];
  logic [NCELL-1:0]                cell_lt;
  logic [NCELL-1:0]                cell_eq;
  logic [NCELL-1:0]                left_l;
  logic [NCELL-1:0]                live;
  logic [NCELL-1:0]                tail;

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign nonpos    = (in_data.price == '0) || in_data.price[dkpw_pkg::PRICE_W-1];
  assign div_start = accept && (in_data.command == dkpw_pkg::CMD_ADD) && !nonpos;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = out_free && ((state_r == ST_RESP) || (state_r == ST_DUMP));

  // effective window limit: zero acts as one, capped at the depth
  always_comb begin
    lim_ext = LIM_W'(lim_r);
    if (lim_r == '0) begin
      eff_lim = LIM_W'(1);
    end else if (lim_ext > LIM_W'(dkpw_pkg::WINDOW_DEPTH)) begin
      eff_lim = LIM_W'(dkpw_pkg::WINDOW_DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign over_limit = LIM_W'(count_r) > eff_lim;
  assign dump_last  = ((dump_idx_r + 1'b1) == count_r);

  // day divider
  dkpw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.tick_secs),
    .done     (div_done),
    .day      (div_day)
  );

  // chain of cells
  assign any_hit = |cell_eq;

  always_comb begin
    ctl.op              = dkpw_pkg::CELL_HOLD;
    ctl.hit             = any_hit;
    ctl.new_entry.day   = div_day;
    ctl.new_entry.price = price_r;
    if (state_r == ST_INS) begin
      ctl.op = dkpw_pkg::CELL_INSERT;
    end else if ((state_r == ST_EVICT) && over_limit) begin
      ctl.op = dkpw_pkg::CELL_SHIFT;
    end else if ((state_r == ST_DUMP) && out_load) begin
      ctl.op = dkpw_pkg::CELL_ROTATE;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam logic [COUNT_W-1:0] IDX    = COUNT_W'(i);
    localparam logic [COUNT_W-1:0] IDX_P1 = COUNT_W'(i + 1);

    assign live[i] = (IDX < count_r);
    assign tail[i] = (count_r == IDX_P1);

    if (i == 0) begin : g_head
      assign left_e[i] = ctl.new_entry;
      assign left_l[i] = 1'b1;
    end else begin : g_body
      assign left_e[i] = cell_e[i-1];
      assign left_l[i] = cell_lt[i-1];
    end

    if (i == NCELL - 1) begin : g_end
      assign right_e[i] = cell_e[i];
    end else begin : g_mid
      assign right_e[i] = cell_e[i+1];
    end

    dkpw_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .left_entry  (left_e[i]),
      .left_lt     (left_l[i]),
      .right_entry (right_e[i]),
      .wrap_entry  (cell_e[0]),
      .live        (live[i]),
      .tail        (tail[i]),
      .entry       (cell_e[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    dump_idx_nxt    = dump_idx_r;
    resp_status_nxt = resp_status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == dkpw_pkg::CMD_DUMP) begin
            resp_status_nxt = dkpw_pkg::STATUS_OK;
            dump_idx_nxt    = '0;
            state_nxt       = (count_r == '0) ? ST_RESP : ST_DUMP;
          end else if (nonpos) begin
            resp_status_nxt = dkpw_pkg::STATUS_REJECT;
            state_nxt       = ST_RESP;
          end else begin
            resp_status_nxt = dkpw_pkg::STATUS_OK;
            state_nxt       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_INS;
      end
      ST_INS: begin
        if (!any_hit) count_nxt = count_r + 1'b1;
        state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        // drop the oldest day once per cycle until within the limit
        if (over_limit) begin
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_load) begin
          dump_idx_nxt = dump_idx_r + 1'b1;
          if (dump_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result build
  always_comb begin
    out_nxt              = out_r;
    out_nxt.fill_count   = dkpw_pkg::FILL_W'(count_r);
    out_nxt.window_ready = (count_r >= COUNT_W'(2));
    if (state_r == ST_DUMP) begin
      out_nxt.status      = dkpw_pkg::STATUS_OK;
      out_nxt.entry_valid = 1'b1;
      out_nxt.entry_day   = cell_e[0].day;
      out_nxt.entry_price = cell_e[0].price;
      out_nxt.last_result = dump_last;
    end else begin
      out_nxt.status      = resp_status_r;
      out_nxt.entry_valid = 1'b0;
      out_nxt.entry_day   = '0;
      out_nxt.entry_price = '0;
      out_nxt.last_result = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      lim_r       <= dkpw_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
      if (cfg_valid && cfg_ready) lim_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    resp_status_r <= resp_status_nxt;
    if (accept) price_r <= in_data.price;
    if (out_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (dump_idx_r < count_r))
    else $error("dump index ran past the stored days");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(NCELL))
    else $error("stored day count exceeds the cell chain");

  a_ins_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> (state_r == ST_EVICT))
    else $error("insert not followed by the eviction check");

endmodule
`default_nettype wire
